FILE: sv/msk_pkg.sv
// types, codes and constants shared by the row sorter
// no dependencies; compile first

package msk_pkg;

   localparam int MaxRows  = 1024;
   localparam int KeyCount = 4;
   localparam int MaxKeys  = 4;
   localparam int KeyW     = 64;
   localparam int CsrW     = 8;

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_EMIT   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_ROW   = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_DRAIN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_KEY_COUNT   = 2'd0,
      CSR_KEY_TYPES   = 2'd1,
      CSR_ASCENDING   = 2'd2,
      CSR_NULLS_FIRST = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KT_INT32  = 2'd0,
      KT_INT64  = 2'd1,
      KT_DOUBLE = 2'd2,
      KT_BOOL   = 2'd3
   } key_kind_type;

   typedef struct packed {
      logic [2:0] key_count;
      logic [7:0] key_types;
      logic [3:0] ascending_mask;
      logic [3:0] nulls_first_mask;
   } cfg_type;

   typedef struct packed {
      logic [KeyW-1:0] key_a;
      logic [KeyW-1:0] key_b;
      logic [KeyW-1:0] key_c;
      logic [KeyW-1:0] key_d;
      logic [3:0]      nulls;
      logic [KeyW-1:0] payload;
   } row_type;

   localparam int RowW = $bits(row_type);

endpackage

FILE: sv/msk_req_if.sv
// request channel: valid/ready handshake with one row or emit command per beat
// no dependencies

interface msk_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic signed [63:0] key_a;
   logic signed [63:0] key_b;
   logic signed [63:0] key_c;
   logic signed [63:0] key_d;
   logic [3:0]  key_nulls;
   logic [63:0] payload;

   modport source (output valid, opcode, key_a, key_b, key_c, key_d, key_nulls, payload,
                   input ready);
   modport sink   (input valid, opcode, key_a, key_b, key_c, key_d, key_nulls, payload,
                   output ready);
endinterface

FILE: sv/msk_rsp_if.sv
// response channel: valid/ready handshake with one sorted row or status per beat
// no dependencies

interface msk_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic signed [63:0] sorted_key_a;
   logic signed [63:0] sorted_key_b;
   logic signed [63:0] sorted_key_c;
   logic signed [63:0] sorted_key_d;
   logic [3:0]  sorted_nulls;
   logic [63:0] sorted_payload;
   logic        last_row;

   modport source (output valid, status, sorted_key_a, sorted_key_b, sorted_key_c,
                   sorted_key_d, sorted_nulls, sorted_payload, last_row, input ready);
   modport sink   (input valid, status, sorted_key_a, sorted_key_b, sorted_key_c,
                   sorted_key_d, sorted_nulls, sorted_payload, last_row, output ready);
endinterface

FILE: sv/msk_ram.sv
// synchronous ram, one write port and two read ports with registered data
// no dependencies

module msk_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr_a,
   input  logic [$clog2(Depth)-1:0] raddr_b,
   output logic [Width-1:0]         rdata_a,
   output logic [Width-1:0]         rdata_b
);

   logic [Width-1:0] mem [Depth];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read ports, data held while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a <= mem[raddr_a];
         rdata_b <= mem[raddr_b];
      end
   end

endmodule

FILE: sv/msk_cmp.sv
// row comparator: flags when the right row sorts strictly before the left one
// depends on msk_pkg

module msk_cmp (
   input  msk_pkg::cfg_type cfg,
   input  msk_pkg::row_type row_left,
   input  msk_pkg::row_type row_right,
   output logic             right_first
);
   import msk_pkg::*;

   logic [KeyW-1:0] key_l [KeyCount];
   logic [KeyW-1:0] key_r [KeyCount];
   logic [KeyCount-1:0] v_lt;
   logic [KeyCount-1:0] v_gt;
   logic [2:0] used;

   // value compare of right against left, per key
   function automatic logic [1:0] cmp_value(input logic [1:0] kind,
                                            input logic [KeyW-1:0] x,
                                            input logic [KeyW-1:0] y);
      logic lt;
      logic gt;
      logic nan;
      logic zeros;
      logic [KeyW-1:0] ox;
      logic [KeyW-1:0] oy;
      lt = 1'b0;
      gt = 1'b0;
      nan = (&x[62:52] && |x[51:0]) || (&y[62:52] && |y[51:0]);
      zeros = (x[62:0] == 63'd0) && (y[62:0] == 63'd0);
      ox = x[63] ? ~x : (x | {1'b1, 63'd0});
      oy = y[63] ? ~y : (y | {1'b1, 63'd0});
      case (kind)
         KT_INT32: begin
            lt = $signed(x[31:0]) < $signed(y[31:0]);
            gt = $signed(x[31:0]) > $signed(y[31:0]);
         end
         KT_INT64: begin
            lt = $signed(x) < $signed(y);
            gt = $signed(x) > $signed(y);
         end
         KT_DOUBLE: begin
            lt = !nan && !zeros && (ox < oy);
            gt = !nan && !zeros && (ox > oy);
         end
         default: begin
            lt = x[7:0] < y[7:0];
            gt = x[7:0] > y[7:0];
         end
      endcase
      return {lt, gt};
   endfunction

   assign key_l[0] = row_left.key_a;
   assign key_l[1] = row_left.key_b;
   assign key_l[2] = row_left.key_c;
   assign key_l[3] = row_left.key_d;
   assign key_r[0] = row_right.key_a;
   assign key_r[1] = row_right.key_b;
   assign key_r[2] = row_right.key_c;
   assign key_r[3] = row_right.key_d;

   // keys in use, clamped to what exists
   always_comb begin
      used = cfg.key_count;
      if (used > 3'(MaxKeys)) used = 3'(MaxKeys);
      if (used > 3'(KeyCount)) used = 3'(KeyCount);
   end

   // independent value compares
   always_comb begin
      for (int k = 0; k < KeyCount; k++) begin
         {v_lt[k], v_gt[k]} = cmp_value(cfg.key_types[2*k +: 2], key_r[k], key_l[k]);
      end
   end

   // priority chain, first deciding key wins
   always_comb begin
      logic done;
      logic rn;
      logic ln;
      logic nf;
      done = 1'b0;
      right_first = 1'b0;
      for (int k = 0; k < KeyCount; k++) begin
         rn = row_right.nulls[k];
         ln = row_left.nulls[k];
         nf = cfg.nulls_first_mask[k];
         if (!done && (3'(k) < used) && !(rn && ln)) begin
            if (rn) begin
               done = 1'b1;
               right_first = nf;
            end else if (ln) begin
               done = 1'b1;
               right_first = !nf;
            end else if (v_lt[k] || v_gt[k]) begin
               done = 1'b1;
               right_first = cfg.ascending_mask[k] ? v_lt[k] : v_gt[k];
            end
         end
      end
   end

endmodule

FILE: sv/multi_key_stable_row_sort.sv
// top level of the stable multi-key row sorter: row store, order buffers, sequencer
// depends on msk_pkg, msk_req_if, msk_rsp_if, msk_ram, msk_cmp
//
//   channel   dir   handshake        beat
//   req_ch    in    valid/ready      append a row or request the next sorted row
//   rsp_ch    out   valid/ready      sorted row or append rejection status
//   csr_*     in    write enable     register index and data, no read-back
//
// an append is taken in S_IDLE, a rejected append passes through S_REJ; an emit reads the index
// (S_EIDX), then the row (S_EROW), and loads it in S_OUT once the output slot is free
// the first emit runs a bottom-up merge sort first: ceil(log2(n)) passes, each with an index
// read, a row read and a compare per row, a setup step per run and a step to close the pass
// no clearing pass after reset; only rows below the fill count are read
// req_ch.ready is low while a command is being worked on or its result waits

module multi_key_stable_row_sort #(
   parameter int MAX_ROWS = msk_pkg::MaxRows
) (
   input  logic                  clock,
   input  logic                  reset,
   msk_req_if.sink               req_ch,
   msk_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  msk_pkg::csr_index_type csr_index,
   input  logic [msk_pkg::CsrW-1:0] csr_wdata
);
   import msk_pkg::*;

   localparam int AW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_ROWS + 1);
   localparam int PW = CW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_REJ, S_RUN, S_IDX, S_ROW, S_CMP, S_EIDX, S_EROW, S_OUT
   } state_type;

   state_type state_ff;
   cfg_type   cfg_ff;

   logic [CW-1:0] count_ff, ptr_ff, lo_ff, mid_ff, hi_ff, l_ff, r_ff, o_ff;
   logic [PW-1:0] w_ff;
   logic          sel_ff, ident_ff, draining_ff;
   logic [AW-1:0] idx_l_ff, idx_r_ff;
   status_type    rej_ff;

   logic          row_we, row_re;
   logic [AW-1:0] row_raddr_a, row_raddr_b;
   row_type       row_wdata, row_a, row_b;
   logic          ob_re, ob_we0, ob_we1;
   logic [AW-1:0] ob_raddr_a, ob_raddr_b;
   logic [AW-1:0] ob0_a, ob0_b, ob1_a, ob1_b, src_a, src_b, sel_l, sel_r, ob_wdata;
   logic          right_first, take_r, req_fire, slot_free, last, rsp_load;
   logic [PW-1:0] mid_in, hi_in, w_dbl;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_count        <= 3'd1;
         cfg_ff.key_types        <= 8'd0;
         cfg_ff.ascending_mask   <= 4'hF;
         cfg_ff.nulls_first_mask <= 4'h0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_COUNT:   cfg_ff.key_count        <= csr_wdata[2:0];
            CSR_KEY_TYPES:   cfg_ff.key_types        <= csr_wdata[7:0];
            CSR_ASCENDING:   cfg_ff.ascending_mask   <= csr_wdata[3:0];
            CSR_NULLS_FIRST: cfg_ff.nulls_first_mask <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // row store and the two ping-pong order buffers
   msk_ram #(.Width(RowW), .Depth(MAX_ROWS)) u_rows (
      .clock, .we(row_we), .waddr(count_ff[AW-1:0]), .wdata(row_wdata), .re(row_re),
      .raddr_a(row_raddr_a), .raddr_b(row_raddr_b), .rdata_a(row_a), .rdata_b(row_b)
   );
   msk_ram #(.Width(AW), .Depth(MAX_ROWS)) u_order0 (
      .clock, .we(ob_we0), .waddr(o_ff[AW-1:0]), .wdata(ob_wdata), .re(ob_re),
      .raddr_a(ob_raddr_a), .raddr_b(ob_raddr_b), .rdata_a(ob0_a), .rdata_b(ob0_b)
   );
   msk_ram #(.Width(AW), .Depth(MAX_ROWS)) u_order1 (
      .clock, .we(ob_we1), .waddr(o_ff[AW-1:0]), .wdata(ob_wdata), .re(ob_re),
      .raddr_a(ob_raddr_a), .raddr_b(ob_raddr_b), .rdata_a(ob1_a), .rdata_b(ob1_b)
   );

   msk_cmp u_cmp (.cfg(cfg_ff), .row_left(row_a), .row_right(row_b), .right_first);

   assign row_wdata = '{key_a: req_ch.key_a, key_b: req_ch.key_b, key_c: req_ch.key_c,
                        key_d: req_ch.key_d, nulls: req_ch.key_nulls,
                        payload: req_ch.payload};

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);
   assign slot_free    = !rsp_ch.valid || rsp_ch.ready;
   assign rsp_load     = slot_free && ((state_ff == S_REJ) || (state_ff == S_OUT));

   // source buffer select; the first pass reads the identity order
   assign src_a = sel_ff ? ob1_a : ob0_a;
   assign src_b = sel_ff ? ob1_b : ob0_b;
   assign sel_l = ident_ff ? l_ff[AW-1:0] : src_a;
   assign sel_r = ident_ff ? r_ff[AW-1:0] : src_b;

   // merge choice: right head when the left run is empty, or when it remains and sorts strictly before the left head
   assign take_r   = (l_ff >= mid_ff) || ((r_ff < hi_ff) && right_first);
   assign ob_wdata = take_r ? idx_r_ff : idx_l_ff;

   assign mid_in = (PW'(lo_ff) + w_ff < PW'(count_ff)) ? PW'(lo_ff) + w_ff : PW'(count_ff);
   assign hi_in  = (mid_in + w_ff < PW'(count_ff)) ? mid_in + w_ff : PW'(count_ff);
   assign w_dbl  = w_ff << 1;
   assign last   = (PW'(ptr_ff) + PW'(1)) >= PW'(count_ff);

   // memory port control
   always_comb begin
      row_we      = req_fire && (req_ch.opcode == OP_APPEND) && !draining_ff &&
                    (count_ff != CW'(MAX_ROWS));
      row_re      = 1'b0;
      row_raddr_a = sel_l;
      row_raddr_b = sel_r;
      ob_re       = 1'b0;
      ob_raddr_a  = l_ff[AW-1:0];
      ob_raddr_b  = r_ff[AW-1:0];
      ob_we0      = 1'b0;
      ob_we1      = 1'b0;
      case (state_ff)
         S_IDX:  ob_re = (o_ff < hi_ff);
         S_EIDX: begin
            ob_re      = 1'b1;
            ob_raddr_a = ptr_ff[AW-1:0];
         end
         S_ROW:  row_re = 1'b1;
         S_EROW: begin
            row_re      = 1'b1;
            row_raddr_a = ident_ff ? ptr_ff[AW-1:0] : src_a;
         end
         S_CMP: begin
            ob_we0 = sel_ff;
            ob_we1 = !sel_ff;
         end
         default: ;
      endcase
   end

   // sequencer: appends, merge passes, emits and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         draining_ff  <= 1'b0;
         rsp_ch.valid <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready && !rsp_load) rsp_ch.valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_ch.opcode == OP_APPEND) begin
                     if (draining_ff) begin
                        rej_ff   <= STATUS_DRAIN;
                        state_ff <= S_REJ;
                     end else if (count_ff == CW'(MAX_ROWS)) begin
                        rej_ff   <= STATUS_FULL;
                        state_ff <= S_REJ;
                     end else begin
                        count_ff <= count_ff + CW'(1);
                     end
                  end else if (draining_ff) begin
                     state_ff <= S_EIDX;
                  end else if (count_ff == CW'(1)) begin
                     draining_ff <= 1'b1;
                     ptr_ff      <= '0;
                     ident_ff    <= 1'b1;
                     state_ff    <= S_EIDX;
                  end else if (count_ff != '0) begin
                     w_ff     <= PW'(1);
                     lo_ff    <= '0;
                     sel_ff   <= 1'b0;
                     ident_ff <= 1'b1;
                     state_ff <= S_RUN;
                  end
               end
            end
            S_REJ: begin
               if (slot_free) begin
                  rsp_ch.valid          <= 1'b1;
                  rsp_ch.status         <= rej_ff;
                  rsp_ch.sorted_key_a   <= '0;
                  rsp_ch.sorted_key_b   <= '0;
                  rsp_ch.sorted_key_c   <= '0;
                  rsp_ch.sorted_key_d   <= '0;
                  rsp_ch.sorted_nulls   <= '0;
                  rsp_ch.sorted_payload <= '0;
                  rsp_ch.last_row       <= 1'b0;
                  state_ff              <= S_IDLE;
               end
            end
            S_RUN: begin
               if (lo_ff >= count_ff) begin
                  // pass finished
                  sel_ff   <= !sel_ff;
                  ident_ff <= 1'b0;
                  lo_ff    <= '0;
                  w_ff     <= w_dbl;
                  if (w_dbl >= PW'(count_ff)) begin
                     draining_ff <= 1'b1;
                     ptr_ff      <= '0;
                     state_ff    <= S_EIDX;
                  end
               end else begin
                  mid_ff   <= CW'(mid_in);
                  hi_ff    <= CW'(hi_in);
                  l_ff     <= lo_ff;
                  r_ff     <= CW'(mid_in);
                  o_ff     <= lo_ff;
                  state_ff <= S_IDX;
               end
            end
            S_IDX: begin
               if (o_ff >= hi_ff) begin
                  lo_ff    <= hi_ff;
                  state_ff <= S_RUN;
               end else begin
                  state_ff <= S_ROW;
               end
            end
            S_ROW: begin
               idx_l_ff <= sel_l;
               idx_r_ff <= sel_r;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (take_r) r_ff <= r_ff + CW'(1);
               else        l_ff <= l_ff + CW'(1);
               o_ff     <= o_ff + CW'(1);
               state_ff <= S_IDX;
            end
            S_EIDX: state_ff <= S_EROW;
            S_EROW: state_ff <= S_OUT;
            S_OUT: begin
               if (slot_free) begin
                  rsp_ch.valid          <= 1'b1;
                  rsp_ch.status         <= STATUS_ROW;
                  rsp_ch.sorted_key_a   <= row_a.key_a;
                  rsp_ch.sorted_key_b   <= row_a.key_b;
                  rsp_ch.sorted_key_c   <= row_a.key_c;
                  rsp_ch.sorted_key_d   <= row_a.key_d;
                  rsp_ch.sorted_nulls   <= row_a.nulls;
                  rsp_ch.sorted_payload <= row_a.payload;
                  rsp_ch.last_row       <= last;
                  if (last) begin
                     draining_ff <= 1'b0;
                     count_ff    <= '0;
                     ptr_ff      <= '0;
                  end else begin
                     ptr_ff <= ptr_ff + CW'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: test/testbench.sv
// self-checking testbench for the stable multi-key row sorter
// depends on msk_pkg, msk_req_if, msk_rsp_if and multi_key_stable_row_sort
`timescale 1ns / 1ps

module testbench;
   import msk_pkg::*;

   localparam int Depth = MaxRows;

   typedef struct {
      status_type status;
      row_type    row;
      logic       last;
   } sorted_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_KEY_COUNT;
   logic [CsrW-1:0] csr_wdata = '0;

   msk_req_if req_ch ();
   msk_rsp_if rsp_ch ();

   multi_key_stable_row_sort dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state: row store, sorted order and registers
   row_type     row_mem [Depth];
   int unsigned sort_order [Depth];
   int unsigned merge_buf [Depth];
   int unsigned fill_count;
   int unsigned next_out;
   bit          in_drain;
   cfg_type     sort_cfg;

   sorted_beat_type pending_rows [$];
   bit          failed;
   int unsigned items_sent;
   int unsigned cycle_count;
   bit          calm;

   // cycle count and a calm window with no idling on either side
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      calm <= (cycle_count % 5000) < 700;
   end

   // sink side stalls at random
   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 38);
   end

   function automatic logic [63:0] key_field(row_type r, int k);
      case (k)
         0: return r.key_a;
         1: return r.key_b;
         2: return r.key_c;
         default: return r.key_d;
      endcase
   endfunction

   function automatic int value_order(key_kind_type kind, logic [63:0] a, logic [63:0] b);
      real x, y;
      case (kind)
         KT_INT32: begin
            if ($signed(a[31:0]) < $signed(b[31:0])) return -1;
            if ($signed(a[31:0]) > $signed(b[31:0])) return 1;
            return 0;
         end
         KT_INT64: begin
            if ($signed(a) < $signed(b)) return -1;
            if ($signed(a) > $signed(b)) return 1;
            return 0;
         end
         KT_DOUBLE: begin
            x = $bitstoreal(a);
            y = $bitstoreal(b);
            // a nan compares neither below nor above, so it ties
            if (x < y) return -1;
            if (x > y) return 1;
            return 0;
         end
         default: begin
            if (a[7:0] < b[7:0]) return -1;
            if (a[7:0] > b[7:0]) return 1;
            return 0;
         end
      endcase
   endfunction

   function automatic int row_order(int unsigned ra, int unsigned rb);
      int n;
      int c;
      bit an, bn, nf;
      n = sort_cfg.key_count;
      if (n > MaxKeys) n = MaxKeys;
      for (int k = 0; k < n; k++) begin
         an = row_mem[ra].nulls[k];
         bn = row_mem[rb].nulls[k];
         nf = sort_cfg.nulls_first_mask[k];
         if (an && bn) continue;
         if (an) return nf ? -1 : 1;
         if (bn) return nf ? 1 : -1;
         c = value_order(key_kind_type'(sort_cfg.key_types[2*k +: 2]),
                         key_field(row_mem[ra], k), key_field(row_mem[rb], k));
         if (c != 0) return sort_cfg.ascending_mask[k] ? c : -c;
      end
      return 0;
   endfunction

   // bottom-up merge sort; right head wins only when strictly lower
   function automatic void sort_store();
      int unsigned n, mid, hi, l, r, o;
      n = fill_count;
      for (int unsigned i = 0; i < n; i++) sort_order[i] = i;
      for (int unsigned w = 1; w < n; w *= 2) begin
         for (int unsigned lo = 0; lo < n; lo += 2 * w) begin
            mid = (lo + w < n) ? lo + w : n;
            hi = (mid + w < n) ? mid + w : n;
            l = lo;
            r = mid;
            o = lo;
            while (l < mid && r < hi) begin
               if (row_order(sort_order[r], sort_order[l]) < 0) begin
                  merge_buf[o] = sort_order[r];
                  r++;
               end else begin
                  merge_buf[o] = sort_order[l];
                  l++;
               end
               o++;
            end
            while (l < mid) begin
               merge_buf[o] = sort_order[l];
               l++;
               o++;
            end
            while (r < hi) begin
               merge_buf[o] = sort_order[r];
               r++;
               o++;
            end
         end
         for (int unsigned i = 0; i < n; i++) sort_order[i] = merge_buf[i];
      end
   endfunction

   // work out the result of one accepted beat
   function automatic void predict_beat(opcode_type op, row_type row);
      sorted_beat_type e;
      e.status = STATUS_ROW;
      e.row = '0;
      e.last = 1'b0;
      if (op == OP_APPEND) begin
         if (in_drain || fill_count >= Depth) begin
            e.status = in_drain ? STATUS_DRAIN : STATUS_FULL;
            pending_rows.insert(pending_rows.size(), e);
         end else begin
            row_mem[fill_count] = row;
            fill_count++;
         end
         return;
      end
      if (!in_drain) begin
         if (fill_count == 0) return;
         sort_store();
         in_drain = 1'b1;
         next_out = 0;
      end
      e.row = row_mem[sort_order[next_out]];
      e.last = (next_out + 1 >= fill_count);
      pending_rows.insert(pending_rows.size(), e);
      if (e.last) begin
         in_drain = 1'b0;
         fill_count = 0;
         next_out = 0;
      end else begin
         next_out++;
      end
   endfunction

   // compare every result beat with the oldest expectation
   always @(posedge clock) begin
      sorted_beat_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rows.size() == 0) begin
            $display("%0t: unexpected beat, status %0d payload %h", $time,
                     rsp_ch.status, rsp_ch.sorted_payload);
            failed = 1'b1;
         end else begin
            e = pending_rows.pop_front();
            if (rsp_ch.status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_ch.status);
               failed = 1'b1;
            end
            if (rsp_ch.sorted_key_a !== e.row.key_a) begin
               $display("%0t: key_a expected %h actual %h", $time, e.row.key_a,
                        rsp_ch.sorted_key_a);
               failed = 1'b1;
            end
            if (rsp_ch.sorted_key_b !== e.row.key_b) begin
               $display("%0t: key_b expected %h actual %h", $time, e.row.key_b,
                        rsp_ch.sorted_key_b);
               failed = 1'b1;
            end
            if (rsp_ch.sorted_key_c !== e.row.key_c) begin
               $display("%0t: key_c expected %h actual %h", $time, e.row.key_c,
                        rsp_ch.sorted_key_c);
               failed = 1'b1;
            end
            if (rsp_ch.sorted_key_d !== e.row.key_d) begin
               $display("%0t: key_d expected %h actual %h", $time, e.row.key_d,
                        rsp_ch.sorted_key_d);
               failed = 1'b1;
            end
            if (rsp_ch.sorted_nulls !== e.row.nulls) begin
               $display("%0t: nulls expected %h actual %h", $time, e.row.nulls,
                        rsp_ch.sorted_nulls);
               failed = 1'b1;
            end
            if (rsp_ch.sorted_payload !== e.row.payload) begin
               $display("%0t: payload expected %h actual %h", $time, e.row.payload,
                        rsp_ch.sorted_payload);
               failed = 1'b1;
            end
            if (rsp_ch.last_row !== e.last) begin
               $display("%0t: last_row expected %b actual %b", $time, e.last,
                        rsp_ch.last_row);
               failed = 1'b1;
            end
         end
      end
   end

   // one request beat, at times with a random gap in front
   task automatic send_beat(opcode_type op, row_type row);
      if (!calm && $urandom_range(99) < 38) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.key_a <= row.key_a;
      req_ch.key_b <= row.key_b;
      req_ch.key_c <= row.key_c;
      req_ch.key_d <= row.key_d;
      req_ch.key_nulls <= row.nulls;
      req_ch.payload <= row.payload;
      do @(posedge clock); while (!req_ch.ready);
      predict_beat(op, row);
      items_sent++;
   endtask

   // drop valid and hold off until every expected beat has come
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_config(cfg_type c);
      csr_we <= 1'b1;
      csr_index <= CSR_KEY_COUNT;
      csr_wdata <= CsrW'(c.key_count);
      @(posedge clock);
      csr_index <= CSR_KEY_TYPES;
      csr_wdata <= c.key_types;
      @(posedge clock);
      csr_index <= CSR_ASCENDING;
      csr_wdata <= CsrW'(c.ascending_mask);
      @(posedge clock);
      csr_index <= CSR_NULLS_FIRST;
      csr_wdata <= CsrW'(c.nulls_first_mask);
      @(posedge clock);
      csr_we <= 1'b0;
      sort_cfg = c;
   endtask

   // key words biased towards ties, extremes and double specials
   function automatic logic [63:0] pick_key();
      case ($urandom_range(9))
         0, 1: return {$urandom, $urandom};
         2, 3: return 64'($urandom_range(3));
         4: return {32'h0, $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
         5: return $urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
         6: return $urandom_range(1) ? 64'h0 : 64'h8000_0000_0000_0000;
         7: return $urandom_range(1) ? 64'h7ff8_0000_0000_0000 : 64'h7ff0_0000_0000_0000;
         8: return $urandom_range(1) ? 64'hfff0_0000_0000_0000 : 64'h3ff0_0000_0000_0000;
         default: return {$urandom_range(1) ? 32'hffff_ffff : 32'h0, $urandom};
      endcase
   endfunction

   function automatic row_type pick_row();
      row_type r;
      r.key_a = pick_key();
      r.key_b = pick_key();
      r.key_c = pick_key();
      r.key_d = pick_key();
      r.nulls = ($urandom_range(2) == 0) ? 4'($urandom) : 4'h0;
      r.payload = {$urandom, $urandom};
      return r;
   endfunction

   function automatic cfg_type pick_config();
      cfg_type c;
      c.key_count = ($urandom_range(7) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
      c.key_types = 8'($urandom);
      c.ascending_mask = 4'($urandom);
      c.nulls_first_mask = 4'($urandom);
      return c;
   endfunction

   // extremes, every operation, drain rejection and empty emit
   task automatic test_directed();
      row_type r;
      cfg_type c;
      r = '0;
      send_beat(OP_EMIT, r);
      r.key_a = 64'h8000_0000_0000_0000;
      r.payload = 64'hffff_ffff_ffff_ffff;
      send_beat(OP_APPEND, r);
      r.key_a = 64'h7fff_ffff_ffff_ffff;
      r.key_b = 64'hffff_ffff_ffff_ffff;
      r.key_c = 64'hffff_ffff_ffff_ffff;
      r.key_d = 64'hffff_ffff_ffff_ffff;
      r.nulls = 4'hf;
      r.payload = 64'h0;
      send_beat(OP_APPEND, r);
      r = '0;
      r.key_a = 64'h0000_0000_8000_0000;
      r.payload = 64'h1;
      send_beat(OP_APPEND, r);
      r.key_a = 64'h0000_0000_8000_0000;
      r.payload = 64'h2;
      send_beat(OP_APPEND, r);
      send_beat(OP_EMIT, r);
      send_beat(OP_APPEND, r);
      repeat (3) send_beat(OP_EMIT, r);
      send_beat(OP_EMIT, r);
      wait_idle();

      // doubles with nan, signed zeros and negative infinity, descending, nulls first
      c.key_count = 3'd2;
      c.key_types = {2'(KT_BOOL), 2'(KT_INT32), 2'(KT_INT64), 2'(KT_DOUBLE)};
      c.ascending_mask = 4'b1110;
      c.nulls_first_mask = 4'b0011;
      load_config(c);
      r = '0;
      r.key_a = 64'h7ff8_0000_0000_0000;
      r.payload = 64'h10;
      send_beat(OP_APPEND, r);
      r.key_a = 64'h8000_0000_0000_0000;
      r.payload = 64'h11;
      send_beat(OP_APPEND, r);
      r.key_a = 64'hfff0_0000_0000_0000;
      r.payload = 64'h12;
      send_beat(OP_APPEND, r);
      r.nulls = 4'b0001;
      r.payload = 64'h13;
      send_beat(OP_APPEND, r);
      r.key_a = 64'h0;
      r.nulls = 4'b0;
      r.key_b = 64'h8000_0000_0000_0000;
      r.payload = 64'h14;
      send_beat(OP_APPEND, r);
      repeat (5) send_beat(OP_EMIT, r);
      wait_idle();
   endtask

   // mostly small fill and drain runs with random content, stray emits and rejected appends
   task automatic test_random_runs();
      int unsigned n;
      int unsigned stop_at;
      row_type r;
      stop_at = items_sent + 700;
      r = '0;
      while (items_sent < stop_at) begin
         load_config(pick_config());
         n = ($urandom_range(15) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
         if ($urandom_range(7) == 0) send_beat(OP_EMIT, r);
         for (int unsigned i = 0; i < n; i++) send_beat(OP_APPEND, pick_row());
         for (int unsigned i = 0; i < n; i++) begin
            send_beat(OP_EMIT, r);
            if (i + 1 < n && $urandom_range(9) == 0) send_beat(OP_APPEND, pick_row());
         end
         wait_idle();
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_APPEND;
      req_ch.key_a = '0;
      req_ch.key_b = '0;
      req_ch.key_c = '0;
      req_ch.key_d = '0;
      req_ch.key_nulls = '0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      failed = 1'b0;
      items_sent = 0;
      cycle_count = 0;
      calm = 1'b0;
      fill_count = 0;
      next_out = 0;
      in_drain = 1'b0;
      sort_cfg.key_count = 3'd1;
      sort_cfg.key_types = 8'h00;
      sort_cfg.ascending_mask = 4'hf;
      sort_cfg.nulls_first_mask = 4'h0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_runs();
      wait_idle();
      if (!failed) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
sv/msk_pkg.sv
sv/msk_req_if.sv
sv/msk_rsp_if.sv
sv/msk_ram.sv
sv/msk_cmp.sv
sv/multi_key_stable_row_sort.sv
test/testbench.sv
